FILE: design/ordered_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Shorthand for the concurrent checks used in the engine's RTL.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ordered list engine: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ordered list engine: assertion failed");

`endif

FILE: design/ole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Shared types, codes and constants of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VAL_W        = 32;
	localparam int LEN_W        = 8;

	typedef logic [LEN_W-1:0]        len_t;
	typedef logic signed [VAL_W-1:0] val_t;

	typedef enum logic [2:0] {
		FN_CLEAR,
		FN_INS_FRONT,
		FN_INS_END,
		FN_INS_POS,
		FN_REM_FRONT,
		FN_REM_END,
		FN_REM_POS,
		FN_SEARCH
	} func_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_EMPTY,
		ST_BADPOS,
		ST_FULL,
		ST_NOTFOUND
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_OPEN,
		OP_CLOSE,
		OP_SEARCH
	} cell_op_t;

	typedef struct packed {
		func_t func;
		val_t  value;
		len_t  position;
	} req_t;

	typedef struct packed {
		status_t status;
		val_t    result_value;
		len_t    found_index;
		len_t    length;
	} res_t;

	typedef struct packed {
		cell_op_t op;
		len_t     idx;
		len_t     cnt;
		val_t     key;
	} cell_cmd_t;

	typedef struct packed {
		status_t status;
		len_t    new_len;
		logic    search;
		logic    take;
	} dec_t;

endpackage

FILE: design/ole_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list engine request decoder
// Checks a request against the fill level and turns it into a cell command.
// ----------------------------------------------------------------------------
module ole_ctrl #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input  logic              en,
	input  ole_pkg::req_t     req,
	input  ole_pkg::len_t     cnt,
	output ole_pkg::cell_cmd_t cmd,
	output ole_pkg::dec_t     dec
);

	logic [ole_pkg::LEN_W:0] cnt_p1;
	ole_pkg::len_t           pos_idx;
	logic                    full;
	logic                    empty;
	logic                    ins_pos_ok;
	logic                    rem_pos_ok;

	always_comb begin
		cnt_p1     = {1'b0, cnt} + {{ole_pkg::LEN_W{1'b0}}, 1'b1};
		pos_idx    = req.position - ole_pkg::len_t'(1);
		full       = cnt >= ole_pkg::len_t'(CAPACITY);
		empty      = cnt == '0;
		ins_pos_ok = (req.position != '0) && ({1'b0, req.position} <= cnt_p1);
		rem_pos_ok = (req.position != '0) && (req.position <= cnt);
	end

	always_comb begin
		cmd.op      = ole_pkg::OP_HOLD;
		cmd.idx     = '0;
		cmd.cnt     = cnt;
		cmd.key     = req.value;
		dec.status  = ole_pkg::ST_OK;
		dec.new_len = cnt;
		dec.search  = 1'b0;
		dec.take    = 1'b0;
		unique case (req.func) inside
			ole_pkg::FN_CLEAR: begin
				dec.new_len = '0;
			end
			ole_pkg::FN_INS_FRONT, ole_pkg::FN_INS_END, ole_pkg::FN_INS_POS: begin
				if (full) begin
					dec.status = ole_pkg::ST_FULL;
				end else if (req.func == ole_pkg::FN_INS_POS && !ins_pos_ok) begin
					dec.status = ole_pkg::ST_BADPOS;
				end else begin
					cmd.op      = ole_pkg::OP_OPEN;
					dec.new_len = cnt + ole_pkg::len_t'(1);
					cmd.idx     = (req.func == ole_pkg::FN_INS_FRONT) ? '0 :
						(req.func == ole_pkg::FN_INS_END) ? cnt : pos_idx;
				end
			end
			ole_pkg::FN_REM_FRONT, ole_pkg::FN_REM_END, ole_pkg::FN_REM_POS: begin
				if (empty) begin
					dec.status = ole_pkg::ST_EMPTY;
				end else if (req.func == ole_pkg::FN_REM_POS && !rem_pos_ok) begin
					dec.status = ole_pkg::ST_BADPOS;
				end else begin
					cmd.op      = ole_pkg::OP_CLOSE;
					dec.take    = 1'b1;
					dec.new_len = cnt - ole_pkg::len_t'(1);
					cmd.idx     = (req.func == ole_pkg::FN_REM_FRONT) ? '0 :
						(req.func == ole_pkg::FN_REM_END) ? cnt - ole_pkg::len_t'(1) : pos_idx;
				end
			end
			ole_pkg::FN_SEARCH: begin
				cmd.op     = ole_pkg::OP_SEARCH;
				dec.search = 1'b1;
			end
			default: begin
			end
		endcase
		if (!en) begin
			cmd.op = ole_pkg::OP_HOLD;
		end
	end

endmodule

FILE: design/ole_cell.sv
// ----------------------------------------------------------------------------
// Ordered list engine cell
// Holds one list entry, shifts to or from its neighbours and compares a key.
// ----------------------------------------------------------------------------
module ole_cell #(
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  ole_pkg::cell_cmd_t cmd,
	input  ole_pkg::val_t      left,
	input  ole_pkg::val_t      right,
	output ole_pkg::val_t      entry,
	output logic               match,
	output ole_pkg::val_t      pick
);

	localparam ole_pkg::len_t ME = ole_pkg::len_t'(INDEX);

	ole_pkg::val_t entry_q;
	ole_pkg::val_t pick_q;
	logic          match_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			ole_pkg::OP_OPEN: begin
				if (ME > cmd.idx) begin
					entry_q <= left;
				end else if (ME == cmd.idx) begin
					entry_q <= cmd.key;
				end
			end
			ole_pkg::OP_CLOSE: begin
				if (ME >= cmd.idx) begin
					entry_q <= right;
				end
				pick_q <= (ME == cmd.idx) ? entry_q : '0;
			end
			ole_pkg::OP_SEARCH: begin
				match_q <= (ME < cmd.cnt) && (entry_q == cmd.key);
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign match = match_q;
	assign pick  = pick_q;

endmodule

FILE: design/ole_find.sv
// ----------------------------------------------------------------------------
// Ordered list engine match reducer
// Finds the first matching cell and gathers the value taken from the list.
// ----------------------------------------------------------------------------
module ole_find #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input  logic [CAPACITY-1:0] match,
	input  ole_pkg::val_t       pick [CAPACITY],
	output logic                hit,
	output ole_pkg::len_t       loc,
	output ole_pkg::val_t       picked
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int P  = 1 << IW;
	localparam int N  = 2 * P;

	logic          hit_n [1:N-1];
	logic [IW-1:0] loc_n [1:N-1];
	ole_pkg::val_t acc_n [1:N-1];

	always_comb begin
		for (int i = 0; i < P; i++) begin
			if (i < CAPACITY) begin
				hit_n[P+i] = match[i];
				acc_n[P+i] = pick[i];
			end else begin
				hit_n[P+i] = 1'b0;
				acc_n[P+i] = '0;
			end
			loc_n[P+i] = IW'(i);
		end
		for (int n = P - 1; n >= 1; n--) begin
			hit_n[n] = hit_n[2*n] | hit_n[2*n+1];
			loc_n[n] = hit_n[2*n] ? loc_n[2*n] : loc_n[2*n+1];
			acc_n[n] = acc_n[2*n] | acc_n[2*n+1];
		end
	end

	assign hit    = hit_n[1];
	assign loc    = ole_pkg::len_t'(loc_n[1]);
	assign picked = acc_n[1];

endmodule

FILE: design/ordered_list_engine.sv
// A request is registered in req_s1; the cell row updates in the cycle after
// acceptance, the match tree in the next, and the result goes to res_q once the
// output is free. No request is taken until the one ahead can load its result.
// Reset: arst_n clears the fill count and the pipeline flags; list entries are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of signed values held in a row of shifting cells.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_assert.svh"

module ordered_list_engine #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  ole_pkg::req_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output ole_pkg::res_t res
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic               accept;
	logic               load;
	logic               v_s1_q;
	logic               v_s2_q;
	logic [CW-1:0]      count_q;
	ole_pkg::req_t      req_s1;
	ole_pkg::cell_cmd_t cell_cmd;
	ole_pkg::dec_t      dec;
	ole_pkg::status_t   status_s2;
	ole_pkg::len_t      len_s2;
	logic               search_s2;
	logic               take_s2;
	ole_pkg::val_t      key_s2;
	ole_pkg::val_t      entry_w [CAPACITY];
	ole_pkg::val_t      pick_w [CAPACITY];
	logic [CAPACITY-1:0] match_w;
	logic               hit;
	ole_pkg::len_t      loc;
	ole_pkg::val_t      picked;
	ole_pkg::res_t      res_next;
	ole_pkg::res_t      res_q;
	logic               res_valid_q;

	assign accept    = cmd_valid && !cmd_stall;
	assign load      = v_s2_q && (!res_valid_q || !res_stall);
	assign cmd_stall = v_s1_q || (v_s2_q && !load);

	ole_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.en (v_s1_q),
		.req(req_s1),
		.cnt(ole_pkg::len_t'(count_q)),
		.cmd(cell_cmd),
		.dec(dec)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ole_pkg::val_t left_w;
		ole_pkg::val_t right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_inner_l
			assign left_w = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner_r
			assign right_w = entry_w[i+1];
		end

		ole_cell #(
			.INDEX(i)
		) u_cell (
			.clk  (clk),
			.cmd  (cell_cmd),
			.left (left_w),
			.right(right_w),
			.entry(entry_w[i]),
			.match(match_w[i]),
			.pick (pick_w[i])
		);
	end

	ole_find #(
		.CAPACITY(CAPACITY)
	) u_find (
		.match (match_w),
		.pick  (pick_w),
		.hit   (hit),
		.loc   (loc),
		.picked(picked)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1_q <= accept;
			v_s2_q <= v_s1_q || (v_s2_q && !load);
			if (v_s1_q) begin
				count_q <= CW'(dec.new_len);
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= cmd;
		end
		if (v_s1_q) begin
			status_s2 <= dec.status;
			len_s2    <= dec.new_len;
			search_s2 <= dec.search;
			take_s2   <= dec.take;
			key_s2    <= req_s1.value;
		end
		if (load) begin
			res_q <= res_next;
		end
	end

	always_comb begin
		res_next.status       = status_s2;
		res_next.result_value = '0;
		res_next.found_index  = '0;
		res_next.length       = len_s2;
		if (search_s2) begin
			if (hit) begin
				res_next.result_value = key_s2;
				res_next.found_index  = loc + ole_pkg::len_t'(1);
			end else begin
				res_next.status = ole_pkg::ST_NOTFOUND;
			end
		end else if (take_s2) begin
			res_next.result_value = picked;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`OLE_ASSERT_IMP(a_one_in_flight, clk, arst_n, 1'b1, !(v_s1_q && v_s2_q))
	`OLE_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`OLE_ASSERT_NXT(a_accept_starts, clk, arst_n, accept, v_s1_q && !v_s2_q)
	`OLE_ASSERT_NXT(a_full_keeps, clk, arst_n, v_s1_q && dec.status == ole_pkg::ST_FULL, $stable(count_q))
	`OLE_ASSERT_NXT(a_wait_holds, clk, arst_n, v_s2_q && !load, v_s2_q && !v_s1_q)

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Sends list requests through the engine with random gaps and stalls on both
// sides. A predictor keeps its own copy of the list and works out the result
// of every accepted request. Each returned result is checked field by field
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CAPACITY    = ole_pkg::CAPACITY_DEF;
	localparam int RANDOM_REQS = 800;
	localparam int HOLD_CYCLES = 200;
	localparam int WATCHDOG    = 5000;
	localparam int TAIL_CYCLES = 8;

	typedef struct {
		ole_pkg::req_t req;
		int unsigned   gap;
		bit            drain;
		bit            hold;
	} plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	ole_pkg::req_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	ole_pkg::res_t res;

	plan_t         plan_q[$];
	ole_pkg::res_t res_due[$];
	plan_t         head;
	bit            have_head;
	int unsigned   gap_left;
	bit            cmd_taken;
	bit            res_taken;
	bit            hold_ask;
	int unsigned   stall_left;
	int unsigned   quiet_left;
	int unsigned   cmds_done;
	int unsigned   idle_cycles;
	int unsigned   errors;

	ole_pkg::val_t list_mem[CAPACITY];
	int            list_len;

	bit            calm;
	bit            drain_next;
	bit            hold_next;
	int            rush_left;
	ole_pkg::val_t pool[8];

	ordered_list_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic ole_pkg::res_t list_apply(ole_pkg::req_t r);
		ole_pkg::res_t o;
		int            p;
		int            k;
		int            j;
		o = '0;
		o.status = ole_pkg::ST_OK;
		p = int'(r.position);
		case (r.func)
			ole_pkg::FN_CLEAR: begin
				list_len = 0;
			end
			ole_pkg::FN_INS_FRONT, ole_pkg::FN_INS_END, ole_pkg::FN_INS_POS: begin
				if (list_len >= CAPACITY) begin
					o.status = ole_pkg::ST_FULL;
				end else if (r.func == ole_pkg::FN_INS_POS && (p < 1 || p > list_len + 1)) begin
					o.status = ole_pkg::ST_BADPOS;
				end else begin
					k = (r.func == ole_pkg::FN_INS_FRONT) ? 0 :
						(r.func == ole_pkg::FN_INS_END) ? list_len : p - 1;
					for (j = list_len; j > k; j--)
						list_mem[j] = list_mem[j - 1];
					list_mem[k] = r.value;
					list_len++;
				end
			end
			ole_pkg::FN_REM_FRONT, ole_pkg::FN_REM_END, ole_pkg::FN_REM_POS: begin
				if (list_len == 0) begin
					o.status = ole_pkg::ST_EMPTY;
				end else if (r.func == ole_pkg::FN_REM_POS && (p < 1 || p > list_len)) begin
					o.status = ole_pkg::ST_BADPOS;
				end else begin
					k = (r.func == ole_pkg::FN_REM_FRONT) ? 0 :
						(r.func == ole_pkg::FN_REM_END) ? list_len - 1 : p - 1;
					o.result_value = list_mem[k];
					for (j = k; j + 1 < list_len; j++)
						list_mem[j] = list_mem[j + 1];
					list_len--;
				end
			end
			default: begin
				o.status = ole_pkg::ST_NOTFOUND;
				for (j = 0; j < list_len; j++) begin
					if (o.status == ole_pkg::ST_NOTFOUND && list_mem[j] == r.value) begin
						o.status = ole_pkg::ST_OK;
						o.result_value = r.value;
						o.found_index = ole_pkg::len_t'(j + 1);
					end
				end
			end
		endcase
		o.length = ole_pkg::len_t'(list_len);
		return o;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
		end
	endtask

	task automatic queue_cmd(ole_pkg::func_t f, ole_pkg::val_t v, int p);
		plan_t e;
		e.req.func = f;
		e.req.value = v;
		e.req.position = ole_pkg::len_t'(p);
		e.gap = (calm || rush_left > 0) ? 0 : $urandom_range(0, 16);
		e.drain = drain_next;
		e.hold = hold_next;
		drain_next = 1'b0;
		hold_next = 1'b0;
		if (rush_left > 0)
			rush_left--;
		plan_q.push_back(e);
	endtask

	function automatic ole_pkg::val_t pick_value();
		if ($urandom_range(0, 9) < 6)
			return pool[$urandom_range(0, 7)];
		return ole_pkg::val_t'($urandom);
	endfunction

	function automatic int pick_position();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 255);
		return $urandom_range(0, CAPACITY + 1);
	endfunction

	// Sender: a request stays on the bus until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_taken)) begin
			if (!have_head && plan_q.size() != 0) begin
				head = plan_q.pop_front();
				have_head = 1'b1;
				gap_left = head.gap;
			end
			if (have_head && head.drain && res_due.size() != 0) begin
				cmd_valid <= 1'b0;
			end else if (have_head && gap_left != 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (have_head) begin
				cmd_valid <= 1'b1;
				cmd <= head.req;
				if (head.hold)
					hold_ask = 1'b1;
				have_head = 1'b0;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls a drawn number of cycles after results not in quiet runs.
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				if (quiet_left != 0) begin
					quiet_left--;
					stall_left = 0;
				end else if ($urandom_range(0, 15) == 0) begin
					quiet_left = 40;
					stall_left = 0;
				end else begin
					stall_left = $urandom_range(0, 16);
				end
			end
			if (hold_ask) begin
				hold_ask = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		ole_pkg::res_t want;
		if (arst_n) begin
			cmd_taken = cmd_valid && !cmd_stall;
			res_taken = res_valid && !res_stall;
			if (cmd_taken) begin
				res_due.push_back(list_apply(cmd));
				cmds_done++;
			end
			if (res_taken) begin
				if (res_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %p", $realtime, res);
				end else begin
					want = res_due.pop_front();
					compare_field("status", 32'(want.status), 32'(res.status));
					compare_field("result_value", 32'(want.result_value),
						32'(res.result_value));
					compare_field("found_index", 32'(want.found_index), 32'(res.found_index));
					compare_field("length", 32'(want.length), 32'(res.length));
				end
			end
			idle_cycles = (cmd_taken || res_taken) ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("%0t: no request or result moved for %0d cycles", $realtime, WATCHDOG);
				$display("FAIL ordered_list_engine");
				$finish;
			end
		end
	end

	initial begin
		int unsigned    total;
		int             burst;
		int             kind;
		int             n;
		ole_pkg::func_t f;
		pool = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd5,
			32'sh55555555, 32'shaaaaaaaa};

		queue_cmd(ole_pkg::FN_SEARCH, 0, 0);
		queue_cmd(ole_pkg::FN_REM_FRONT, 0, 0);
		queue_cmd(ole_pkg::FN_REM_END, 0, 0);
		queue_cmd(ole_pkg::FN_REM_POS, 0, 1);
		queue_cmd(ole_pkg::FN_INS_POS, 7, 0);
		queue_cmd(ole_pkg::FN_INS_POS, 7, 2);
		queue_cmd(ole_pkg::FN_INS_POS, 0, 1);
		queue_cmd(ole_pkg::FN_INS_FRONT, 32'sh7fffffff, 0);
		queue_cmd(ole_pkg::FN_INS_END, 32'sh80000000, 0);
		queue_cmd(ole_pkg::FN_INS_POS, -1, 4);
		queue_cmd(ole_pkg::FN_INS_POS, 0, 2);
		queue_cmd(ole_pkg::FN_SEARCH, 0, 0);
		queue_cmd(ole_pkg::FN_SEARCH, 32'sh80000000, 0);
		queue_cmd(ole_pkg::FN_SEARCH, 123, 0);
		queue_cmd(ole_pkg::FN_REM_POS, 0, 0);
		queue_cmd(ole_pkg::FN_REM_POS, 0, 6);
		queue_cmd(ole_pkg::FN_REM_POS, 0, 255);
		queue_cmd(ole_pkg::FN_INS_POS, 9, 255);
		queue_cmd(ole_pkg::FN_REM_POS, 0, 1);
		queue_cmd(ole_pkg::FN_REM_END, 0, 0);
		queue_cmd(ole_pkg::FN_REM_FRONT, 0, 0);
		queue_cmd(ole_pkg::FN_CLEAR, 0, 0);
		queue_cmd(ole_pkg::FN_SEARCH, 0, 0);

		total = plan_q.size() + RANDOM_REQS;
		burst = 0;
		while (plan_q.size() < total) begin
			kind = (burst == 0) ? 0 : $urandom_range(0, 9);
			calm = ($urandom_range(0, 4) == 0);
			drain_next = (burst == 1) || ($urandom_range(0, 3) == 0);
			if (burst == 0 || burst == 15) begin
				hold_next = 1'b1;
				rush_left = 40;
			end
			for (n = $urandom_range(10, 40); n > 0; n--) begin
				case (kind)
					0, 1, 2, 3: f = ($urandom_range(0, 19) < 17)
						? ole_pkg::func_t'($urandom_range(1, 3))
						: ole_pkg::func_t'($urandom_range(4, 7));
					4, 5: f = ($urandom_range(0, 3) != 0)
						? ole_pkg::func_t'($urandom_range(4, 6))
						: ole_pkg::func_t'($urandom_range(1, 3));
					6, 7: f = ($urandom_range(0, 39) == 0) ? ole_pkg::FN_CLEAR
						: ole_pkg::func_t'($urandom_range(1, 7));
					8: f = ole_pkg::func_t'($urandom_range(0, 7));
					default: f = $urandom_range(0, 1) ? ole_pkg::FN_SEARCH
						: ole_pkg::func_t'($urandom_range(1, 3));
				endcase
				if (kind == 8)
					queue_cmd(f, ole_pkg::val_t'($urandom), $urandom_range(0, 255));
				else
					queue_cmd(f, pick_value(), pick_position());
			end
			burst++;
		end
		total = plan_q.size();

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		wait (cmds_done == total && res_due.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS ordered_list_engine");
		else
			$display("FAIL ordered_list_engine");
		$finish;
	end

endmodule
